FILE: hw/rtl/led_driver_chain_frame_generator_defines.svh
// assertion macros for the led driver chain frame generator
// used by the top level only; no other dependencies
`ifndef LED_DRIVER_CHAIN_FRAME_GENERATOR_DEFINES_SVH
`define LED_DRIVER_CHAIN_FRAME_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LDCFG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LDCFG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LDCFG_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define LDCFG_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/ldcfg_pkg.sv
// shared types, constants and helper functions of the led driver chain frame generator
// no dependencies
package ldcfg_pkg;

    localparam int MAX_DEVICES     = 8;
    localparam int ROWS_PER_DEVICE = 8;
    // five init frames of up to eight words fit the result limit
    localparam int CHAIN_CAP       = (MAX_DEVICES < 8) ? MAX_DEVICES : 8;
    localparam int POS_W           = (CHAIN_CAP > 1) ? $clog2(CHAIN_CAP) : 1;
    localparam int NUM_INIT_FRAMES = 5;
    localparam int FIFO_DEPTH      = 2;
    localparam int FIFO_PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [2:0] REG_DEVICE_COUNT = 3'd0;
    localparam logic [2:0] REG_DECODE_MODE  = 3'd1;
    localparam logic [2:0] REG_INTENSITY    = 3'd2;
    localparam logic [2:0] REG_SCAN_LIMIT   = 3'd3;
    localparam logic [2:0] REG_TEST_MODE    = 3'd4;
    localparam logic [2:0] REG_POWER_ON     = 3'd5;
    localparam logic [2:0] REG_MIRROR       = 3'd6;

    // request kinds
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_ROW  = 1'b1;

    // driver register addresses
    localparam logic [3:0] ADDR_NOOP      = 4'h0;
    localparam logic [3:0] ADDR_DECODE    = 4'h9;
    localparam logic [3:0] ADDR_INTENSITY = 4'hA;
    localparam logic [3:0] ADDR_SCANLIM   = 4'hB;
    localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
    localparam logic [3:0] ADDR_TEST      = 4'hF;

    // init frame order
    localparam logic [2:0] FRAME_DECODE    = 3'd0;
    localparam logic [2:0] FRAME_INTENSITY = 3'd1;
    localparam logic [2:0] FRAME_SCANLIM   = 3'd2;
    localparam logic [2:0] FRAME_TEST      = 3'd3;
    localparam logic [2:0] FRAME_SHUTDOWN  = 3'd4;

    typedef struct packed {
        logic [3:0] device_count;
        logic [7:0] decode_mode;
        logic [3:0] intensity;
        logic [2:0] scan_limit;
        logic       test_mode;
        logic       power_on;
        logic       mirror;
    } cfg_t;

    typedef struct packed {
        logic       is_init;
        logic [2:0] target;
        logic [3:0] addr;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic [2:0] pos;
        logic [2:0] frame;
    } seq_status_t;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } fifo_status_t;

    function automatic logic [7:0] flip_byte(input logic [7:0] v);
        logic [7:0] t;
        t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
        t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
        return t;
    endfunction

    // effective chain length, 1..CHAIN_CAP
    function automatic logic [3:0] chain_len(input logic [3:0] dc);
        logic [3:0] n;
        n = (dc == 4'd0) ? 4'd1 : dc;
        if (int'(n) > CHAIN_CAP) begin
            n = 4'(CHAIN_CAP);
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/led_driver_chain_frame_generator.sv
// Frame generator for a daisy chain of 8x8 LED display drivers. A row request gives one
// frame of n words (n = device_count clamped to 1..8), an init request five frames, 5*n
// words. The word sequencer emits one word per cycle into the output register while the
// result side does not stall; requests queue in a two-entry command buffer and are taken
// every cycle while it has room.
// A row request with a row beyond the device is taken and gives no words.
// Depends on ldcfg_pkg, ldcfg_front, ldcfg_fifo, ldcfg_back and the defines header.
`include "led_driver_chain_frame_generator_defines.svh"

module led_driver_chain_frame_generator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [2:0] s_target_device,
    input  logic [2:0] s_row,
    input  logic [7:0] s_row_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_reg_addr,
    output logic [7:0] m_reg_data,
    output logic       m_frame_end,
    output logic       m_last
);

    ldcfg_pkg::cfg_t          cfg_reg, cfg_next;
    ldcfg_pkg::cmd_t          push_cmd;
    ldcfg_pkg::cmd_t          head_cmd;
    ldcfg_pkg::fifo_status_t  fifo_st;
    ldcfg_pkg::seq_status_t   seq_st;
    logic                     push;
    logic                     pop;
    logic [3:0]               chain_n;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ldcfg_pkg::REG_DEVICE_COUNT: cfg_next.device_count = cfg_wdata[3:0];
                ldcfg_pkg::REG_DECODE_MODE:  cfg_next.decode_mode  = cfg_wdata;
                ldcfg_pkg::REG_INTENSITY:    cfg_next.intensity    = cfg_wdata[3:0];
                ldcfg_pkg::REG_SCAN_LIMIT:   cfg_next.scan_limit   = cfg_wdata[2:0];
                ldcfg_pkg::REG_TEST_MODE:    cfg_next.test_mode    = cfg_wdata[0];
                ldcfg_pkg::REG_POWER_ON:     cfg_next.power_on     = cfg_wdata[0];
                ldcfg_pkg::REG_MIRROR:       cfg_next.mirror       = cfg_wdata[0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_count <= 4'd1;
            cfg_reg.decode_mode  <= 8'd0;
            cfg_reg.intensity    <= 4'd15;
            cfg_reg.scan_limit   <= 3'd7;
            cfg_reg.test_mode    <= 1'b0;
            cfg_reg.power_on     <= 1'b1;
            cfg_reg.mirror       <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ldcfg_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_target_device (s_target_device),
        .s_row           (s_row),
        .s_row_data      (s_row_data),
        .mirror          (cfg_reg.mirror),
        .fifo_full       (fifo_st.full),
        .push            (push),
        .cmd             (push_cmd)
    );

    ldcfg_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_cmd),
        .pop     (pop),
        .dout    (head_cmd),
        .status  (fifo_st)
    );

    ldcfg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd_valid   (!fifo_st.empty),
        .cmd         (head_cmd),
        .cmd_pop     (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_reg_addr  (m_reg_addr),
        .m_reg_data  (m_reg_data),
        .m_frame_end (m_frame_end),
        .m_last      (m_last),
        .status      (seq_st)
    );

    assign chain_n = ldcfg_pkg::chain_len(cfg_reg.device_count);

    `LDCFG_ASSERT_IMP(a_last_ends_frame, aclk, aresetn, m_valid && m_last, m_frame_end, "last word without frame end")
    `LDCFG_ASSERT_IMP(a_pos_in_chain, aclk, aresetn, 1'b1, {1'b0, seq_st.pos} < chain_n, "chain position past chain length")
    `LDCFG_ASSERT_IMP(a_frame_in_range, aclk, aresetn, 1'b1, seq_st.frame <= ldcfg_pkg::FRAME_SHUTDOWN, "init frame index out of range")
    `LDCFG_ASSERT_IMP(a_fifo_bound, aclk, aresetn, 1'b1, int'(fifo_st.count) <= ldcfg_pkg::FIFO_DEPTH, "command queue overflow")
    `LDCFG_ASSERT_NXT(a_request_continues, aclk, aresetn, m_valid && m_ready && !m_last, m_valid, "gap inside the words of one request")

endmodule

FILE: hw/rtl/ldcfg_front.sv
// front end: accepts requests, drops out-of-range rows, builds commands for the queue
// depends on ldcfg_pkg
module ldcfg_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [2:0]         s_target_device,
    input  logic [2:0]         s_row,
    input  logic [7:0]         s_row_data,
    input  logic               mirror,
    input  logic               fifo_full,
    output logic               push,
    output ldcfg_pkg::cmd_t    cmd
);

    logic accept;
    logic drop;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;
    // a row beyond the device gives no words at all
    assign drop    = (s_kind == ldcfg_pkg::KIND_ROW) &&
                     ({1'b0, s_row} >= 4'(ldcfg_pkg::ROWS_PER_DEVICE));
    assign push    = accept && !drop;

    always_comb begin
        cmd.is_init = (s_kind == ldcfg_pkg::KIND_INIT);
        cmd.target  = s_target_device;
        cmd.addr    = {1'b0, s_row} + 4'd1;
        cmd.data    = mirror ? ldcfg_pkg::flip_byte(s_row_data) : s_row_data;
    end

endmodule

FILE: hw/rtl/ldcfg_fifo.sv
// short command queue between front end and word sequencer
// depends on ldcfg_pkg
module ldcfg_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ldcfg_pkg::cmd_t        din,
    input  logic                   pop,
    output ldcfg_pkg::cmd_t        dout,
    output ldcfg_pkg::fifo_status_t status
);

    ldcfg_pkg::cmd_t mem [ldcfg_pkg::FIFO_DEPTH];

    logic [ldcfg_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ldcfg_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ldcfg_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == ldcfg_pkg::FIFO_DEPTH - 1) ? '0 :
                          wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == ldcfg_pkg::FIFO_DEPTH - 1) ? '0 :
                          rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout         = mem[rd_ptr_reg];
    assign status.full  = (int'(count_reg) == ldcfg_pkg::FIFO_DEPTH);
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

FILE: hw/rtl/ldcfg_back.sv
// back end: walks chain positions and init frames, one word per cycle into the output register
// while the output is not stalled; depends on ldcfg_pkg
module ldcfg_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ldcfg_pkg::cfg_t         cfg,
    input  logic                    cmd_valid,
    input  ldcfg_pkg::cmd_t         cmd,
    output logic                    cmd_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [3:0]              m_reg_addr,
    output logic [7:0]              m_reg_data,
    output logic                    m_frame_end,
    output logic                    m_last,
    output ldcfg_pkg::seq_status_t  status
);

    logic [ldcfg_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [2:0]                  frame_reg, frame_next;
    logic                        m_valid_reg, m_valid_next;
    logic [3:0]                  addr_reg;
    logic [7:0]                  data_reg;
    logic                        fend_reg;
    logic                        last_reg;

    logic [3:0] n;
    logic       load;
    logic       pos_last;
    logic       frame_last;
    logic [3:0] w_addr;
    logic [7:0] w_data;
    logic       w_last;

    assign n          = ldcfg_pkg::chain_len(cfg.device_count);
    assign load       = cmd_valid && (!m_valid_reg || m_ready);
    assign pos_last   = (4'(pos_reg) == n - 4'd1);
    assign frame_last = (frame_reg == ldcfg_pkg::FRAME_SHUTDOWN);

    always_comb begin
        w_addr = ldcfg_pkg::ADDR_NOOP;
        w_data = 8'd0;
        w_last = pos_last;
        if (cmd.is_init) begin
            w_last = pos_last && frame_last;
            unique case (frame_reg)
                ldcfg_pkg::FRAME_DECODE: begin
                    w_addr = ldcfg_pkg::ADDR_DECODE;
                    w_data = cfg.decode_mode;
                end
                ldcfg_pkg::FRAME_INTENSITY: begin
                    w_addr = ldcfg_pkg::ADDR_INTENSITY;
                    w_data = {4'd0, cfg.intensity};
                end
                ldcfg_pkg::FRAME_SCANLIM: begin
                    w_addr = ldcfg_pkg::ADDR_SCANLIM;
                    w_data = {5'd0, cfg.scan_limit};
                end
                ldcfg_pkg::FRAME_TEST: begin
                    w_addr = ldcfg_pkg::ADDR_TEST;
                    w_data = {7'd0, cfg.test_mode};
                end
                ldcfg_pkg::FRAME_SHUTDOWN: begin
                    w_addr = ldcfg_pkg::ADDR_SHUTDOWN;
                    w_data = {7'd0, cfg.power_on};
                end
                default: begin
                    w_addr = ldcfg_pkg::ADDR_NOOP;
                    w_data = 8'd0;
                end
            endcase
        end else if ({1'b0, cmd.target} == 4'(pos_reg)) begin
            w_addr = cmd.addr;
            w_data = cmd.data;
        end
    end

    assign cmd_pop = load && w_last;

    always_comb begin
        pos_next   = pos_reg;
        frame_next = frame_reg;
        if (load) begin
            if (w_last) begin
                pos_next   = '0;
                frame_next = ldcfg_pkg::FRAME_DECODE;
            end else if (pos_last) begin
                // next init frame
                pos_next   = '0;
                frame_next = frame_reg + 3'd1;
            end else begin
                pos_next   = pos_reg + 1'b1;
            end
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            frame_reg   <= ldcfg_pkg::FRAME_DECODE;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            frame_reg   <= frame_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            addr_reg <= w_addr;
            data_reg <= w_data;
            fend_reg <= pos_last;
            last_reg <= w_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_reg_addr   = addr_reg;
    assign m_reg_data   = data_reg;
    assign m_frame_end  = fend_reg;
    assign m_last       = last_reg;
    assign status.pos   = 3'(pos_reg);
    assign status.frame = frame_reg;

endmodule

FILE: tb/led_driver_chain_frame_generator_test.sv
// Self-checking testbench for led_driver_chain_frame_generator: drives init and row requests
// through directed and randomized phases and scores every word against a local frame model.
// Depends on ldcfg_pkg and the led_driver_chain_frame_generator RTL.
module led_driver_chain_frame_generator_test;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
        logic       frame_end;
        logic       last;
    } word_t;

    // frame model plus the queue of words still owed by the block
    class frame_scoreboard;
        logic [3:0] device_count;
        logic [7:0] decode_mode;
        logic [3:0] intensity;
        logic [2:0] scan_limit;
        logic       test_mode;
        logic       power_on;
        logic       mirror;
        word_t      owed_words[$];
        int         errors;

        function new();
            device_count = 4'd1;
            decode_mode  = 8'd0;
            intensity    = 4'd15;
            scan_limit   = 3'd7;
            test_mode    = 1'b0;
            power_on     = 1'b1;
            mirror       = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                ldcfg_pkg::REG_DEVICE_COUNT: device_count = val[3:0];
                ldcfg_pkg::REG_DECODE_MODE:  decode_mode  = val;
                ldcfg_pkg::REG_INTENSITY:    intensity    = val[3:0];
                ldcfg_pkg::REG_SCAN_LIMIT:   scan_limit   = val[2:0];
                ldcfg_pkg::REG_TEST_MODE:    test_mode    = val[0];
                ldcfg_pkg::REG_POWER_ON:     power_on     = val[0];
                ldcfg_pkg::REG_MIRROR:       mirror       = val[0];
                default: ;
            endcase
        endfunction

        function int chain_length();
            int n;
            n = int'(device_count);
            if (n == 0) n = 1;
            if (n > ldcfg_pkg::MAX_DEVICES) n = ldcfg_pkg::MAX_DEVICES;
            if (n > 8) n = 8;
            return n;
        endfunction

        function logic [7:0] reverse_bits(logic [7:0] v);
            logic [7:0] r;
            for (int i = 0; i < 8; i++) r[i] = v[7-i];
            return r;
        endfunction

        function void note_request(logic kind, logic [2:0] tgt, logic [2:0] row,
                                   logic [7:0] data);
            int         n;
            logic [3:0] addr;
            logic [7:0] val;
            logic       fend;
            n = chain_length();
            if (kind == ldcfg_pkg::KIND_INIT) begin
                for (int f = 0; f < ldcfg_pkg::NUM_INIT_FRAMES; f++) begin
                    case (3'(f))
                        ldcfg_pkg::FRAME_DECODE: begin
                            addr = ldcfg_pkg::ADDR_DECODE;    val = decode_mode;
                        end
                        ldcfg_pkg::FRAME_INTENSITY: begin
                            addr = ldcfg_pkg::ADDR_INTENSITY; val = 8'(intensity);
                        end
                        ldcfg_pkg::FRAME_SCANLIM: begin
                            addr = ldcfg_pkg::ADDR_SCANLIM;   val = 8'(scan_limit);
                        end
                        ldcfg_pkg::FRAME_TEST: begin
                            addr = ldcfg_pkg::ADDR_TEST;      val = 8'(test_mode);
                        end
                        default: begin
                            addr = ldcfg_pkg::ADDR_SHUTDOWN;  val = 8'(power_on);
                        end
                    endcase
                    for (int p = 0; p < n; p++) begin
                        fend = (p == n - 1);
                        owed_words.push_back({addr, val, fend,
                            fend && (f == ldcfg_pkg::NUM_INIT_FRAMES - 1)});
                    end
                end
                return;
            end
            if (int'(row) >= ldcfg_pkg::ROWS_PER_DEVICE) return;
            val = mirror ? reverse_bits(data) : data;
            for (int p = 0; p < n; p++) begin
                fend = (p == n - 1);
                if (p == int'(tgt))
                    owed_words.push_back({4'(row) + 4'd1, val, fend, fend});
                else
                    owed_words.push_back({ldcfg_pkg::ADDR_NOOP, 8'd0, fend, fend});
            end
        endfunction

        function void check_word(logic [3:0] addr, logic [7:0] data, logic fend, logic lst);
            word_t w;
            if (owed_words.size() == 0) begin
                $error("unexpected word: reg_addr %0h reg_data %0h", addr, data);
                errors++;
                return;
            end
            w = owed_words.pop_front();
            if (addr !== w.reg_addr) begin
                $error("reg_addr: expected %0h, actual %0h", w.reg_addr, addr);
                errors++;
            end
            if (data !== w.reg_data) begin
                $error("reg_data: expected %0h, actual %0h", w.reg_data, data);
                errors++;
            end
            if (fend !== w.frame_end) begin
                $error("frame_end: expected %0b, actual %0b", w.frame_end, fend);
                errors++;
            end
            if (lst !== w.last) begin
                $error("last: expected %0b, actual %0b", w.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return owed_words.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = 3'd0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_kind = 1'b0;
    logic [2:0] s_target_device = 3'd0;
    logic [2:0] s_row = 3'd0;
    logic [7:0] s_row_data = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_reg_addr;
    logic [7:0] m_reg_data;
    logic       m_frame_end;
    logic       m_last;

    bit              quiet_run = 1'b0;
    int              stall_left = 0;
    frame_scoreboard sb = new();

    led_driver_chain_frame_generator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_target_device(s_target_device),
        .s_row          (s_row),
        .s_row_data     (s_row_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reg_addr     (m_reg_addr),
        .m_reg_data     (m_reg_data),
        .m_frame_end    (m_frame_end),
        .m_last         (m_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // result side back-pressure in bursts
    always @(negedge aclk) begin
        if (quiet_run) begin
            stall_left <= 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_reg_addr, m_reg_data, m_frame_end, m_last);
    end

    task automatic write_register(logic [2:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic close_writes();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_request(logic kind, logic [2:0] tgt, logic [2:0] row,
                                logic [7:0] data);
        @(negedge aclk);
        if (!quiet_run && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_target_device <= tgt;
        s_row           <= row;
        s_row_data      <= data;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, tgt, row, data);
    endtask

    task automatic send_random_request();
        logic       kind;
        logic [2:0] tgt;
        int         n;
        n    = sb.chain_length();
        kind = ($urandom_range(0, 6) == 0) ? ldcfg_pkg::KIND_INIT : ldcfg_pkg::KIND_ROW;
        // mostly targets inside the chain, some beyond it
        tgt  = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, n - 1))
                                           : 3'($urandom_range(0, 7));
        send_request(kind, tgt, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    // drop valid and let every owed word drain before touching registers
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset configuration, single device
        send_request(ldcfg_pkg::KIND_INIT, 3'd5, 3'd6, 8'h3C);
        send_request(ldcfg_pkg::KIND_ROW, 3'd0, 3'd0, 8'hA5);
        send_request(ldcfg_pkg::KIND_ROW, 3'd1, 3'd7, 8'hFF);
        drain();

        // full chain, all init values at their opposite extremes, mirroring on
        write_register(ldcfg_pkg::REG_DEVICE_COUNT, 8'hF8);
        write_register(ldcfg_pkg::REG_DECODE_MODE, 8'hFF);
        write_register(ldcfg_pkg::REG_INTENSITY, 8'hF0);
        write_register(ldcfg_pkg::REG_SCAN_LIMIT, 8'hF8);
        write_register(ldcfg_pkg::REG_TEST_MODE, 8'hFF);
        write_register(ldcfg_pkg::REG_POWER_ON, 8'hFE);
        write_register(ldcfg_pkg::REG_MIRROR, 8'h01);
        write_register(REG_UNUSED, 8'h55);
        close_writes();
        send_request(ldcfg_pkg::KIND_INIT, 3'd7, 3'd7, 8'h00);
        send_request(ldcfg_pkg::KIND_ROW, 3'd0, 3'd0, 8'h01);
        send_request(ldcfg_pkg::KIND_ROW, 3'd7, 3'd7, 8'h80);
        send_request(ldcfg_pkg::KIND_ROW, 3'd3, 3'd4, 8'hFF);
        send_request(ldcfg_pkg::KIND_ROW, 3'd5, 3'd2, 8'h00);
        send_request(ldcfg_pkg::KIND_ROW, 3'd1, 3'd1, 8'hC5);
        drain();

        // count above the chain limit saturates
        write_register(ldcfg_pkg::REG_DEVICE_COUNT, 8'h0F);
        write_register(ldcfg_pkg::REG_DECODE_MODE, 8'h00);
        write_register(ldcfg_pkg::REG_INTENSITY, 8'h0F);
        write_register(ldcfg_pkg::REG_SCAN_LIMIT, 8'h07);
        write_register(ldcfg_pkg::REG_TEST_MODE, 8'h00);
        write_register(ldcfg_pkg::REG_POWER_ON, 8'h01);
        write_register(ldcfg_pkg::REG_MIRROR, 8'hFE);
        close_writes();
        send_request(ldcfg_pkg::KIND_INIT, 3'd0, 3'd0, 8'h00);
        send_request(ldcfg_pkg::KIND_ROW, 3'd7, 3'd0, 8'hFF);
        send_request(ldcfg_pkg::KIND_ROW, 3'd2, 3'd6, 8'h3C);
        drain();

        // zero count acts as a single device
        write_register(ldcfg_pkg::REG_DEVICE_COUNT, 8'h00);
        close_writes();
        send_request(ldcfg_pkg::KIND_INIT, 3'd2, 3'd1, 8'h9E);
        send_request(ldcfg_pkg::KIND_ROW, 3'd0, 3'd3, 8'h5A);
        send_request(ldcfg_pkg::KIND_ROW, 3'd4, 3'd3, 8'h5A);

        for (int ph = 0; ph < 12; ph++) begin
            drain();
            for (int idx = 0; idx < 8; idx++) begin
                if ($urandom_range(0, 2) != 0)
                    write_register(3'(idx), 8'($urandom_range(0, 255)));
            end
            close_writes();
            quiet_run = (ph == 11) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 31; i++) begin
                if (ph == 2 && i == 15) drain();
                send_random_request();
            end
        end

        drain();
        repeat (12) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[led_driver_chain_frame_generator] OK");
        end else begin
            if (sb.pending() != 0)
                $error("%0d expected words never arrived", sb.pending());
            $display("[led_driver_chain_frame_generator] ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[led_driver_chain_frame_generator] ERROR");
        $finish;
    end
endmodule
